// ===== hw/rtl/ring_led_additive_renderer_macros.svh =====
// Assertion macros for the ring LED renderer.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef RING_LED_ADDITIVE_RENDERER_MACROS_SVH
`define RING_LED_ADDITIVE_RENDERER_MACROS_SVH

// same-cycle implication
`define RLAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rlar check failed");

// next-cycle implication
`define RLAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rlar check failed");

`endif

// ===== hw/rtl/rlar_pkg.sv =====
// Shared types, constants and helpers for the ring LED renderer.
// No dependencies; used by the datapath, the sequencer and the top level.
package rlar_pkg;

    localparam int PIXELS_DEF = 64;
    localparam int CNT_W      = 7;
    localparam int ACC_W      = 16;
    localparam int COL_W      = 13;
    localparam int POS_W      = 16;
    localparam int S_DATA_W   = 120;
    localparam int S_USER_W   = 3;
    localparam int M_DATA_W   = 32;

    typedef enum logic [2:0] {
        CMD_CLEAR = 3'd0,
        CMD_ADD   = 3'd1,
        CMD_FILL  = 3'd2,
        CMD_LOBE  = 3'd3,
        CMD_RING  = 3'd4,
        CMD_READ  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        DIV_STEP = 2'd0,
        DIV_MOD  = 2'd1,
        DIV_T    = 2'd2
    } t_div_sel;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_MOD, S_STEP, S_PIX, S_TEST, S_TDIV, S_T2, S_K,
        S_WG, S_RD, S_CH0, S_CH1, S_CH2, S_WR, S_NEXT, S_OUT_RD, S_OUT_WAIT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       div_start;
        t_div_sel   div_sel;
        logic       pos_reset;
        logic       step_load;
        logic       pos_adv;
        logic       mod_fix;
        logic       calc_d;
        logic       calc_t2;
        logic       calc_k;
        logic       wg_gain;
        logic       wg_weight;
        logic       rd_issue;
        logic       ch_step;
        logic [1:0] ch_sel;
        logic       wr;
        logic       clear;
        logic       out_load;
    } t_dp_ctrl;

    typedef struct packed {
        t_cmd cmd;
        logic n_zero;
        logic gain_zero;
        logic sigma_zero;
        logic div_busy;
        logic d_ge_sigma;
        logic last_px;
        logic out_free;
    } t_dp_stat;

    function automatic logic [7:0] to_byte(input logic [ACC_W-1:0] v);
        logic [12:0] c;
        logic [20:0] s;
        c = (v > 16'd4096) ? 13'd4096 : v[12:0];
        s = {c, 8'b0} - 21'(c) + 21'd2048;
        return s[19:12];
    endfunction

endpackage

// ===== hw/rtl/rlar_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module rlar_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== hw/rtl/rlar_div.sv =====
// Restoring divider, one quotient bit per cycle, 16-bit divisor.
// Depends on nothing but its ports; used by the renderer datapath.
module rlar_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_init_rem,
    input  logic [16:0] i_low,
    input  logic [4:0]  i_iters,
    input  logic [15:0] i_den,
    output logic        o_busy,
    output logic [16:0] o_quot,
    output logic [15:0] o_rem
);

    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [16:0] r_sh;
    logic [16:0] r_quot;
    logic [15:0] r_den;
    logic [16:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem, r_sh[16]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_iters;
        end else if (r_cnt != 5'd0) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_init_rem;
            r_sh   <= i_low;
            r_quot <= '0;
            r_den  <= i_den;
        end else if (r_cnt != 5'd0) begin
            r_rem  <= w_ge ? 16'(w_trial - {1'b0, r_den}) : w_trial[15:0];
            r_sh   <= {r_sh[15:0], 1'b0};
            r_quot <= {r_quot[15:0], w_ge};
        end
    end

    assign o_busy = (r_cnt != 5'd0);
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== hw/rtl/rlar_datapath.sv =====
// Datapath of the renderer: pixel store, divider, falloff math, output register.
// Depends on rlar_pkg, rlar_div and rlar_ram.
module rlar_datapath #(
    parameter int PIXELS = rlar_pkg::PIXELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [rlar_pkg::CNT_W-1:0]     i_pixel_count,
    input  logic [rlar_pkg::S_DATA_W-1:0]  i_s_tdata,
    input  logic [rlar_pkg::S_USER_W-1:0]  i_s_tuser,
    input  rlar_pkg::t_dp_ctrl             i_ctrl,
    output rlar_pkg::t_dp_stat             o_stat,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [rlar_pkg::M_DATA_W-1:0]  o_m_tdata,
    output logic                           o_m_tlast
);

    localparam int IW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam logic [rlar_pkg::CNT_W-1:0] PixMax = rlar_pkg::CNT_W'(PIXELS);

    rlar_pkg::t_cmd    r_cmd;
    logic [15:0]       r_pixel_index;
    logic [15:0]       r_position;
    logic [15:0]       r_radius;
    logic [15:0]       r_sigma;
    logic [12:0]       r_col [3];
    logic [15:0]       r_gain;
    logic [6:0]        r_n;
    logic [6:0]        r_i;
    logic [6:0]        r_tgt;
    logic [16:0]       r_step_q;
    logic [6:0]        r_step_r;
    logic [15:0]       r_p_q;
    logic [6:0]        r_p_r;
    logic [15:0]       r_d;
    logic [15:0]       r_t;
    logic [15:0]       r_t2;
    logic [16:0]       r_k;
    logic [15:0]       r_wg;
    logic [15:0]       r_acc [3];
    logic [PIXELS-1:0] r_valid;
    logic              r_rd_valid;
    logic              r_m_valid;
    logic [29:0]       r_m_data;
    logic              r_m_last;

    logic        w_busy;
    logic [16:0] w_quot;
    logic [15:0] w_rem;
    logic [15:0] w_init_rem;
    logic [16:0] w_low;
    logic [4:0]  w_iters;
    logic [15:0] w_den;
    logic [15:0] w_abs;
    logic [6:0]  w_addr;
    logic [47:0] w_rdata;
    logic [15:0] w_base [3];
    logic [15:0] w_diff;
    logic [15:0] w_fold;
    logic [15:0] w_dist;
    logic [7:0]  w_sum_r;
    logic        w_carry;
    logic [31:0] w_t2p;
    logic [17:0] w_f;
    logic [33:0] w_kp;
    logic [32:0] w_wgp;
    logic [12:0] w_col_sel;
    logic [15:0] w_base_sel;
    logic [28:0] w_cp;
    logic [17:0] w_csum;
    logic [6:0]  w_nsel;

    assign w_nsel = (i_pixel_count > PixMax) ? PixMax : i_pixel_count;
    assign w_abs  = r_pixel_index[15] ? (16'd0 - r_pixel_index) : r_pixel_index;

    always_comb begin
        case (i_ctrl.div_sel)
            rlar_pkg::DIV_MOD: begin
                w_init_rem = '0;
                w_low      = {w_abs, 1'b0};
                w_iters    = 5'd16;
                w_den      = {9'b0, r_n};
            end
            rlar_pkg::DIV_T: begin
                w_init_rem = r_sigma - r_d;
                w_low      = '0;
                w_iters    = 5'd16;
                w_den      = r_sigma;
            end
            default: begin
                w_init_rem = '0;
                w_low      = 17'h10000;
                w_iters    = 5'd17;
                w_den      = {9'b0, r_n};
            end
        endcase
    end

    rlar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctrl.div_start),
        .i_init_rem (w_init_rem),
        .i_low      (w_low),
        .i_iters    (w_iters),
        .i_den      (w_den),
        .o_busy     (w_busy),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign w_addr = (r_cmd == rlar_pkg::CMD_ADD) ? r_tgt : r_i;

    rlar_ram #(
        .WIDTH (48),
        .DEPTH (PIXELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.wr),
        .i_waddr (w_addr[IW-1:0]),
        .i_wdata ({r_acc[2], r_acc[1], r_acc[0]}),
        .i_re    (i_ctrl.rd_issue),
        .i_raddr (w_addr[IW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_base[0] = r_rd_valid ? w_rdata[15:0]  : 16'd0;
    assign w_base[1] = r_rd_valid ? w_rdata[31:16] : 16'd0;
    assign w_base[2] = r_rd_valid ? w_rdata[47:32] : 16'd0;

    assign w_diff = r_p_q - r_position;
    assign w_fold = (w_diff > 16'd32768) ? (16'd0 - w_diff) : w_diff;
    assign w_dist = (r_cmd != rlar_pkg::CMD_RING) ? w_fold :
                    (w_fold >= r_radius) ? (w_fold - r_radius) : (r_radius - w_fold);

    assign w_sum_r = {1'b0, r_p_r} + {1'b0, r_step_r};
    assign w_carry = (w_sum_r >= {1'b0, r_n});

    assign w_t2p = w_quot[15:0] * w_quot[15:0];
    assign w_f   = 18'd196608 - {1'b0, r_t, 1'b0};
    assign w_kp  = r_t2 * w_f;
    assign w_wgp = r_gain * r_k;

    always_comb begin
        case (i_ctrl.ch_sel)
            2'd1: begin
                w_col_sel  = r_col[1];
                w_base_sel = w_base[1];
            end
            2'd2: begin
                w_col_sel  = r_col[2];
                w_base_sel = w_base[2];
            end
            default: begin
                w_col_sel  = r_col[0];
                w_base_sel = w_base[0];
            end
        endcase
    end

    assign w_cp   = w_col_sel * r_wg;
    assign w_csum = {2'b0, w_base_sel} + {1'b0, w_cp[28:12]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_ctrl.clear) begin
                r_valid <= '0;
            end else if (i_ctrl.wr) begin
                r_valid[w_addr[IW-1:0]] <= 1'b1;
            end
            if (i_ctrl.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd         <= rlar_pkg::t_cmd'(i_s_tuser);
            r_pixel_index <= i_s_tdata[15:0];
            r_position    <= i_s_tdata[31:16];
            r_radius      <= i_s_tdata[47:32];
            r_sigma       <= i_s_tdata[63:48];
            r_col[0]      <= i_s_tdata[76:64];
            r_col[1]      <= i_s_tdata[89:77];
            r_col[2]      <= i_s_tdata[102:90];
            r_gain        <= i_s_tdata[118:103];
            r_n           <= w_nsel;
        end
        if (i_ctrl.pos_reset) begin
            r_i   <= '0;
            r_p_q <= '0;
            r_p_r <= '0;
        end else if (i_ctrl.pos_adv) begin
            r_i   <= r_i + 7'd1;
            r_p_r <= w_carry ? 7'(w_sum_r - {1'b0, r_n}) : w_sum_r[6:0];
            r_p_q <= r_p_q + r_step_q[15:0] + {15'b0, w_carry};
        end
        if (i_ctrl.step_load) begin
            r_step_q <= w_quot;
            r_step_r <= w_rem[6:0];
        end
        if (i_ctrl.mod_fix) begin
            r_tgt <= (r_pixel_index[15] && (w_rem != 16'd0)) ? (r_n - w_rem[6:0]) : w_rem[6:0];
        end
        if (i_ctrl.calc_d) begin
            r_d <= w_dist;
        end
        if (i_ctrl.calc_t2) begin
            r_t  <= w_quot[15:0];
            r_t2 <= w_t2p[31:16];
        end
        if (i_ctrl.calc_k) begin
            r_k <= w_kp[32:16];
        end
        if (i_ctrl.wg_gain) begin
            r_wg <= r_gain;
        end else if (i_ctrl.wg_weight) begin
            r_wg <= w_wgp[31:16];
        end
        if (i_ctrl.rd_issue) begin
            r_rd_valid <= r_valid[w_addr[IW-1:0]];
        end
        if (i_ctrl.ch_step) begin
            r_acc[i_ctrl.ch_sel] <= (w_csum > 18'd65535) ? 16'hFFFF : w_csum[15:0];
        end
        if (i_ctrl.out_load) begin
            r_m_data <= {rlar_pkg::to_byte(w_base[2]), rlar_pkg::to_byte(w_base[1]),
                         rlar_pkg::to_byte(w_base[0]), r_i[5:0]};
            r_m_last <= (r_i == r_n - 7'd1);
        end
    end

    assign o_stat.cmd        = r_cmd;
    assign o_stat.n_zero     = (r_n == 7'd0);
    assign o_stat.gain_zero  = (r_gain == 16'd0);
    assign o_stat.sigma_zero = (r_sigma == 16'd0);
    assign o_stat.div_busy   = w_busy;
    assign o_stat.d_ge_sigma = (r_d >= r_sigma);
    assign o_stat.last_px    = (r_i == r_n - 7'd1);
    assign o_stat.out_free   = !r_m_valid || i_m_tready;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {2'b0, r_m_data};
    assign o_m_tlast  = r_m_last;

endmodule

// ===== hw/rtl/rlar_ctrl.sv =====
// Command sequencer of the renderer: walks each command through the datapath.
// Depends on rlar_pkg and the assertion macro header.
`include "ring_led_additive_renderer_macros.svh"

module rlar_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  rlar_pkg::t_dp_stat i_stat,
    output rlar_pkg::t_dp_ctrl o_ctrl
);

    rlar_pkg::t_state r_state;
    rlar_pkg::t_state n_state;
    logic             w_fire;

    assign o_s_tready = (r_state == rlar_pkg::S_IDLE);
    assign w_fire     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlar_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_ctrl  = '0;
        n_state = r_state;
        case (r_state)
            rlar_pkg::S_IDLE: begin
                if (w_fire) begin
                    o_ctrl.load = 1'b1;
                    n_state     = rlar_pkg::S_DECODE;
                end
            end
            rlar_pkg::S_DECODE: begin
                n_state = rlar_pkg::S_IDLE;
                if (!i_stat.n_zero) begin
                    case (i_stat.cmd)
                        rlar_pkg::CMD_CLEAR: begin
                            o_ctrl.clear = 1'b1;
                        end
                        rlar_pkg::CMD_ADD: begin
                            if (!i_stat.gain_zero) begin
                                o_ctrl.div_start = 1'b1;
                                o_ctrl.div_sel   = rlar_pkg::DIV_MOD;
                                n_state          = rlar_pkg::S_MOD;
                            end
                        end
                        rlar_pkg::CMD_FILL: begin
                            if (!i_stat.gain_zero) begin
                                o_ctrl.pos_reset = 1'b1;
                                o_ctrl.wg_gain   = 1'b1;
                                n_state          = rlar_pkg::S_RD;
                            end
                        end
                        rlar_pkg::CMD_LOBE, rlar_pkg::CMD_RING: begin
                            if (!i_stat.gain_zero && !i_stat.sigma_zero) begin
                                o_ctrl.div_start = 1'b1;
                                o_ctrl.div_sel   = rlar_pkg::DIV_STEP;
                                o_ctrl.pos_reset = 1'b1;
                                n_state          = rlar_pkg::S_STEP;
                            end
                        end
                        rlar_pkg::CMD_READ: begin
                            o_ctrl.pos_reset = 1'b1;
                            n_state          = rlar_pkg::S_OUT_RD;
                        end
                        default: begin
                            n_state = rlar_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            rlar_pkg::S_MOD: begin
                if (!i_stat.div_busy) begin
                    o_ctrl.mod_fix = 1'b1;
                    o_ctrl.wg_gain = 1'b1;
                    n_state        = rlar_pkg::S_RD;
                end
            end
            rlar_pkg::S_STEP: begin
                if (!i_stat.div_busy) begin
                    o_ctrl.step_load = 1'b1;
                    n_state          = rlar_pkg::S_PIX;
                end
            end
            rlar_pkg::S_PIX: begin
                o_ctrl.calc_d = 1'b1;
                n_state       = rlar_pkg::S_TEST;
            end
            rlar_pkg::S_TEST: begin
                if (i_stat.d_ge_sigma) begin
                    n_state = rlar_pkg::S_NEXT;
                end else begin
                    o_ctrl.div_start = 1'b1;
                    o_ctrl.div_sel   = rlar_pkg::DIV_T;
                    n_state          = rlar_pkg::S_TDIV;
                end
            end
            rlar_pkg::S_TDIV: begin
                if (!i_stat.div_busy) begin
                    n_state = rlar_pkg::S_T2;
                end
            end
            rlar_pkg::S_T2: begin
                o_ctrl.calc_t2 = 1'b1;
                n_state        = rlar_pkg::S_K;
            end
            rlar_pkg::S_K: begin
                o_ctrl.calc_k = 1'b1;
                n_state       = rlar_pkg::S_WG;
            end
            rlar_pkg::S_WG: begin
                o_ctrl.wg_weight = 1'b1;
                n_state          = rlar_pkg::S_RD;
            end
            rlar_pkg::S_RD: begin
                o_ctrl.rd_issue = 1'b1;
                n_state         = rlar_pkg::S_CH0;
            end
            rlar_pkg::S_CH0: begin
                o_ctrl.ch_step = 1'b1;
                o_ctrl.ch_sel  = 2'd0;
                n_state        = rlar_pkg::S_CH1;
            end
            rlar_pkg::S_CH1: begin
                o_ctrl.ch_step = 1'b1;
                o_ctrl.ch_sel  = 2'd1;
                n_state        = rlar_pkg::S_CH2;
            end
            rlar_pkg::S_CH2: begin
                o_ctrl.ch_step = 1'b1;
                o_ctrl.ch_sel  = 2'd2;
                n_state        = rlar_pkg::S_WR;
            end
            rlar_pkg::S_WR: begin
                o_ctrl.wr = 1'b1;
                n_state   = (i_stat.cmd == rlar_pkg::CMD_ADD) ? rlar_pkg::S_IDLE
                                                               : rlar_pkg::S_NEXT;
            end
            rlar_pkg::S_NEXT: begin
                if (i_stat.last_px) begin
                    n_state = rlar_pkg::S_IDLE;
                end else begin
                    o_ctrl.pos_adv = 1'b1;
                    n_state = (i_stat.cmd == rlar_pkg::CMD_FILL) ? rlar_pkg::S_RD
                                                                  : rlar_pkg::S_PIX;
                end
            end
            rlar_pkg::S_OUT_RD: begin
                o_ctrl.rd_issue = 1'b1;
                n_state         = rlar_pkg::S_OUT_WAIT;
            end
            rlar_pkg::S_OUT_WAIT: begin
                if (i_stat.out_free) begin
                    o_ctrl.out_load = 1'b1;
                    if (i_stat.last_px) begin
                        n_state = rlar_pkg::S_IDLE;
                    end else begin
                        o_ctrl.pos_adv = 1'b1;
                        n_state        = rlar_pkg::S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = rlar_pkg::S_IDLE;
            end
        endcase
    end

    `RLAR_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_fire, !o_s_tready)
    `RLAR_ASSERT_IMPL(a_div_start_idle, i_clk, i_rst_n, o_ctrl.div_start, !i_stat.div_busy)
    `RLAR_ASSERT_IMPL(a_out_load_free, i_clk, i_rst_n, o_ctrl.out_load, i_stat.out_free)
    `RLAR_ASSERT_NEXT(a_single_write, i_clk, i_rst_n, o_ctrl.wr, !o_ctrl.wr)

endmodule

// ===== hw/rtl/ring_led_additive_renderer.sv =====
// Top level of the ring LED renderer: stream ports, register port, sequencer, datapath.
// Depends on rlar_pkg, rlar_ctrl and rlar_datapath.
//
// Additive RGB canvas for a ring of up to PIXELS LEDs, Q4.12 saturating per channel.
// One command is taken at a time on the slave stream; tuser carries the command
// (0 clear, 1 add pixel, 2 fill, 3 lobe, 4 ring, 5 readout). Clear and ignored commands
// go straight back to idle; add pixel runs a serial remainder and a fix-up, then a
// read-modify-write; fill runs a read-modify-write per pixel. Lobe and ring run a divide
// for the pixel spacing, then per pixel a serial divide for the falloff, the multiply and
// a read-modify-write; pixels outside the falloff skip all of these. Readout reads each
// next pixel while the last one waits in the output register, and holds while the master
// stalls. The pixel store starts cleared after reset with no sweep; pixel_count is at
// byte address 0 of the register port.
module ring_led_additive_renderer #(
    parameter int PIXELS = rlar_pkg::PIXELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // pixel_index[15:0] position[31:16] radius[47:32] sigma[63:48] red_in[76:64]
    // green_in[89:77] blue_in[102:90] gain[118:103], zero fill
    input  logic [rlar_pkg::S_DATA_W-1:0] i_s_tdata,
    // cmd[2:0]
    input  logic [rlar_pkg::S_USER_W-1:0] i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // out_index[5:0] red_out[13:6] green_out[21:14] blue_out[29:22], zero fill
    output logic [rlar_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic                          o_m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [rlar_pkg::CNT_W-1:0] r_pixel_count;
    rlar_pkg::t_dp_ctrl         w_ctrl;
    rlar_pkg::t_dp_stat         w_stat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {25'b0, r_pixel_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= 7'd64;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_pixel_count <= pwdata[6:0];
        end
    end

    rlar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    rlar_datapath #(
        .PIXELS (PIXELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_count (r_pixel_count),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_ctrl        (w_ctrl),
        .o_stat        (w_stat),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast)
    );

endmodule

// ===== dv/ring_led_additive_renderer_tb.sv =====
// Self-checking testbench for ring_led_additive_renderer: draw and readout streams with
// a scoreboard that predicts the pixel bytes. Depends on rlar_pkg and the block's RTL.
module ring_led_additive_renderer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic [2:0] ADDR_PIXEL_COUNT = 3'd0;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int SETTLE_CYCLES = 2500;

    typedef struct packed {
        logic        [2:0]  cmd;
        logic signed [15:0] pixel_index;
        logic        [15:0] position;
        logic        [15:0] radius;
        logic        [15:0] sigma;
        logic        [12:0] red;
        logic        [12:0] green;
        logic        [12:0] blue;
        logic        [15:0] gain;
    } t_draw;

    typedef struct packed {
        logic [5:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_pixel_byte;

    class canvas_scoreboard;
        logic [15:0]  acc [rlar_pkg::PIXELS_DEF][3];
        logic [6:0]   pixel_count;
        t_pixel_byte  pending [$];
        int           mismatches;
        int           readouts;
        int           draws;

        function new();
            pixel_count = 7'd64;
            wipe();
        endfunction

        function void wipe();
            foreach (acc[i, c]) acc[i][c] = '0;
        endfunction

        function void accumulate(int idx, t_draw d, logic [31:0] g);
            logic [12:0] col [3];
            logic [47:0] sum;
            col[0] = d.red; col[1] = d.green; col[2] = d.blue;
            for (int c = 0; c < 3; c++) begin
                sum = 48'(acc[idx][c]) + ((48'(col[c]) * 48'(g)) >> 12);
                acc[idx][c] = (sum > 48'd65535) ? 16'hFFFF : sum[15:0];
            end
        endfunction

        function logic [31:0] falloff(logic [31:0] ring_d, logic [31:0] sig);
            logic [63:0] t, t2;
            if (sig == 0 || ring_d >= sig) return 0;
            t = (64'(sig - ring_d) << 16) / 64'(sig);
            t2 = (t * t) >> 16;
            return 32'((t2 * (64'd196608 - 2 * t)) >> 16);
        endfunction

        function logic [7:0] byte_of(logic [15:0] v);
            logic [31:0] c;
            c = (v > 16'd4096) ? 32'd4096 : 32'(v);
            return 8'((c * 255 + 2048) >> 12);
        endfunction

        function void note(t_draw d);
            int n, r;
            logic [31:0] p, ring_d, k;
            t_pixel_byte e;
            n = (pixel_count > 7'd64) ? 64 : int'(pixel_count);
            if (n == 0) return;
            case (d.cmd)
                rlar_pkg::CMD_CLEAR: wipe();
                rlar_pkg::CMD_ADD: if (d.gain != 0) begin
                    r = int'(d.pixel_index) % n;
                    if (r < 0) r += n;
                    accumulate(r, d, 32'(d.gain));
                end
                rlar_pkg::CMD_FILL: if (d.gain != 0)
                    for (int i = 0; i < n; i++) accumulate(i, d, 32'(d.gain));
                rlar_pkg::CMD_LOBE, rlar_pkg::CMD_RING: if (d.gain != 0 && d.sigma != 0) begin
                    for (int i = 0; i < n; i++) begin
                        p = 32'((64'(i) << 16) / 64'(n));
                        ring_d = (p - 32'(d.position)) & 32'hFFFF;
                        if (ring_d > 32768) ring_d = 65536 - ring_d;
                        if (d.cmd == rlar_pkg::CMD_RING)
                            ring_d = (ring_d >= d.radius) ? ring_d - d.radius
                                                          : d.radius - ring_d;
                        k = falloff(ring_d, 32'(d.sigma));
                        if (k != 0) accumulate(i, d, 32'((64'(d.gain) * 64'(k)) >> 16));
                    end
                end
                rlar_pkg::CMD_READ: begin
                    readouts++;
                    for (int i = 0; i < n; i++) begin
                        e.index = 6'(i);
                        e.red = byte_of(acc[i][0]);
                        e.green = byte_of(acc[i][1]);
                        e.blue = byte_of(acc[i][2]);
                        e.last = (i == n - 1);
                        pending.push_back(e);
                    end
                end
                default: ;
            endcase
            if (d.cmd != rlar_pkg::CMD_READ) draws++;
        endfunction

        function void check(logic [rlar_pkg::M_DATA_W-1:0] data, logic last);
            t_pixel_byte got, want;
            got = {data[5:0], data[13:6], data[21:14], data[29:22], last};
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected pixel transaction %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.index != want.index || got.red != want.red || got.green != want.green
                || got.blue != want.blue || got.last != want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"pixel mismatch: exp idx %0d rgb %0d %0d %0d last %0b, ",
                              "got idx %0d rgb %0d %0d %0d last %0b"},
                        want.index, want.red, want.green, want.blue, want.last,
                        got.index, got.red, got.green, got.blue, got.last);
            end
        endfunction
    endclass

    logic                          i_clk, i_rst_n;
    logic                          i_s_tvalid, o_s_tready;
    logic [rlar_pkg::S_DATA_W-1:0] i_s_tdata;
    logic [rlar_pkg::S_USER_W-1:0] i_s_tuser;
    logic                          o_m_tvalid, i_m_tready;
    logic [rlar_pkg::M_DATA_W-1:0] o_m_tdata;
    logic                          o_m_tlast;
    logic                          psel, penable, pwrite, pready;
    logic [2:0]                    paddr;
    logic [31:0]                   pwdata, prdata;

    canvas_scoreboard sb;
    int cycles;
    int burst_left;
    int stall_mode, stall_left;
    int reg_errors;

    ring_led_additive_renderer u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check(o_m_tdata, o_m_tlast);

    // receiver stalls: always ready, coin flip, or long holds
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 300);
        end
        stall_left--;
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= $urandom_range(0, 1);
            default: i_m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic send(t_draw d);
        if (burst_left == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20)) @(negedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        i_s_tuser = d.cmd;
        i_s_tdata = {1'b0, d.gain, d.blue, d.green, d.red, d.sigma, d.radius,
                     d.position, d.pixel_index};
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note(d);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic drain();
        i_s_tvalid = 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_count(logic [6:0] value);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = ADDR_PIXEL_COUNT; pwdata = 32'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        sb.pixel_count = value;
        psel = 1'b1;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata[6:0] != value) begin
            reg_errors++;
            $display("pixel_count readback %0d, wrote %0d", prdata[6:0], value);
        end
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0;
    endtask

    function automatic t_draw make(logic [2:0] c, int idx, int pos, int rad, int sig,
                                   int r, int g, int b, int gn);
        t_draw d;
        d.cmd = c; d.pixel_index = 16'(idx); d.position = 16'(pos); d.radius = 16'(rad);
        d.sigma = 16'(sig); d.red = 13'(r); d.green = 13'(g); d.blue = 13'(b);
        d.gain = 16'(gn);
        return d;
    endfunction

    function automatic t_draw random_draw();
        t_draw d;
        int pick;
        pick = $urandom_range(0, 99);
        d.cmd = pick < 5 ? rlar_pkg::CMD_CLEAR : pick < 30 ? rlar_pkg::CMD_ADD :
                pick < 38 ? rlar_pkg::CMD_FILL : pick < 58 ? rlar_pkg::CMD_LOBE :
                pick < 78 ? rlar_pkg::CMD_RING : pick < 95 ? rlar_pkg::CMD_READ :
                (pick < 97 ? CMD_SPARE_LO : CMD_SPARE_HI);
        d.pixel_index = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                  : 16'($urandom_range(0, 200) - 100);
        d.position = $urandom;
        d.radius = $urandom_range(0, 1) ? 16'($urandom_range(0, 16384)) : 16'($urandom);
        d.sigma = $urandom_range(0, 7) == 0 ? 16'($urandom) :
                  ($urandom_range(0, 15) == 0 ? 16'd0 : 16'($urandom_range(1, 12000)));
        d.red = $urandom_range(0, 7) == 0 ? 13'($urandom) : 13'($urandom_range(0, 4096));
        d.green = $urandom_range(0, 7) == 0 ? 13'($urandom) : 13'($urandom_range(0, 4096));
        d.blue = $urandom_range(0, 7) == 0 ? 13'($urandom) : 13'($urandom_range(0, 4096));
        d.gain = $urandom_range(0, 7) == 0 ? 16'($urandom) :
                 ($urandom_range(0, 15) == 0 ? 16'd0 : 16'($urandom_range(1, 2048)));
        return d;
    endfunction

    initial begin
        logic [6:0] counts [7] = '{7'd64, 7'd1, 7'd0, 7'd37, 7'd127, 7'd7, 7'd64};
        sb = new();
        i_rst_n = 1'b0; i_s_tvalid = 1'b0; i_s_tdata = '0; i_s_tuser = '0;
        i_m_tready = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send(make(rlar_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        send(make(rlar_pkg::CMD_ADD, 32767, 0, 0, 0, 4096, 0, 8191, 4096));
        send(make(rlar_pkg::CMD_ADD, -32768, 0, 0, 0, 0, 4096, 0, 65535));
        send(make(rlar_pkg::CMD_ADD, -1, 0, 0, 0, 2048, 1024, 1, 4096));
        send(make(rlar_pkg::CMD_ADD, 5, 0, 0, 0, 4096, 4096, 4096, 0));
        send(make(rlar_pkg::CMD_FILL, 0, 0, 0, 0, 100, 200, 300, 1024));
        send(make(rlar_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        send(make(rlar_pkg::CMD_LOBE, 0, 0, 0, 0, 4096, 4096, 4096, 4096));
        send(make(rlar_pkg::CMD_LOBE, 0, 0, 0, 65535, 1000, 2000, 3000, 0));
        send(make(rlar_pkg::CMD_LOBE, 0, 0, 0, 65535, 1000, 2000, 3000, 4096));
        send(make(rlar_pkg::CMD_LOBE, 0, 65535, 0, 4000, 4096, 0, 0, 8192));
        send(make(rlar_pkg::CMD_RING, 0, 16384, 65535, 9000, 0, 4096, 0, 4096));
        send(make(rlar_pkg::CMD_RING, 0, 32768, 8192, 3000, 0, 0, 4096, 16384));
        send(make(rlar_pkg::CMD_RING, 0, 0, 0, 1, 4096, 4096, 4096, 65535));
        send(make(CMD_SPARE_LO, 3, 0, 0, 100, 4096, 4096, 4096, 4096));
        send(make(CMD_SPARE_HI, 3, 0, 0, 100, 4096, 4096, 4096, 4096));
        send(make(rlar_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        send(make(rlar_pkg::CMD_FILL, 0, 0, 0, 0, 8191, 8191, 8191, 65535));
        send(make(rlar_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        send(make(rlar_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        send(make(rlar_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));

        foreach (counts[p]) begin
            if (p != 0) begin
                drain();
                write_count(counts[p]);
            end
            repeat (50) send(random_draw());
            send(make(rlar_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        end
        drain();

        $display("covered %0d draw and %0d readout transactions over %0d pixel counts",
                 sb.draws, sb.readouts, $size(counts));
        $display("mismatches %0d, register errors %0d, leftover %0d",
                 sb.mismatches, reg_errors, sb.pending.size());
        if (sb.mismatches == 0 && reg_errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rlar_pkg.sv
hw/rtl/rlar_ram.sv
hw/rtl/rlar_div.sv
hw/rtl/rlar_datapath.sv
hw/rtl/rlar_ctrl.sv
hw/rtl/ring_led_additive_renderer.sv
dv/ring_led_additive_renderer_tb.sv
